// ----- rtl/core/tcsg_pkg.sv -----
// Shared types and constants of the thick circle span generator.
// No dependencies; imported by the core and by its checker.
package tcsg_pkg;

  localparam int VP_BITS       = 10;
  localparam int THICK_BITS    = 8;
  localparam int COLOR_BITS    = 16;
  localparam int SPANS         = 8;
  localparam int SPAN_IDX_BITS = 3;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef enum logic {
    REG_VIEWPORT_X = 1'b0,
    REG_VIEWPORT_Y = 1'b1
  } cfg_reg_t;

  localparam logic [SPAN_IDX_BITS-1:0] SPAN_LAST = SPAN_IDX_BITS'(SPANS - 1);

  // How one of the eight mirrored spans is built from the octant point.
  typedef struct packed {
    logic vertical;   // span runs along a column
    logic fixed_neg;  // fixed coordinate is center minus row offset
    logic along_neg;  // span covers -outer..-inner instead of inner..outer
  } span_sel_t;

  function automatic span_sel_t span_sel(input logic [SPAN_IDX_BITS-1:0] k);
    span_sel_t s;
    s.vertical  = k[0];
    s.fixed_neg = (k inside {3'd3, 3'd4, 3'd5, 3'd6});
    s.along_neg = (k inside {3'd2, 3'd4, 3'd5, 3'd7});
    return s;
  endfunction

endpackage

// ----- rtl/core/thick_circle_span_generator_core.sv -----
// A start or busy step item is registered into the snapshot, then its first span into the output
// register; then one span per cycle while the output is taken, eight spans per item.
// One item is handled at a time, as the single output register drains its eight spans; the
// next item is accepted in the cycle the eighth span is loaded.
// Reset (rst_n low, synchronous): circle state, viewport and all valid flags clear.
// Depends on tcsg_pkg.
module thick_circle_span_generator_core #(
  parameter int RADIUS_BITS = 10,
  parameter int COORD_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic signed [COORD_BITS-1:0]        in_center_x,
  input  logic signed [COORD_BITS-1:0]        in_center_y,
  input  logic [RADIUS_BITS-1:0]              in_radius,
  input  logic [tcsg_pkg::THICK_BITS-1:0]     in_thickness,
  input  logic [tcsg_pkg::COLOR_BITS-1:0]     in_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_vertical,
  output logic signed [COORD_BITS:0]          out_fixed_coord,
  output logic signed [COORD_BITS:0]          out_span_start,
  output logic signed [COORD_BITS:0]          out_span_end,
  output logic [tcsg_pkg::COLOR_BITS-1:0]     out_span_color,
  output logic                                out_last_span,
  input  logic                                cfg_we,
  input  logic [0:0]                          cfg_index,
  input  logic [tcsg_pkg::VP_BITS-1:0]        cfg_wdata
);
  import tcsg_pkg::*;

  localparam int OUT_BITS = COORD_BITS + 1;
  localparam int RB_MIN   = (RADIUS_BITS > THICK_BITS - 1) ? RADIUS_BITS : THICK_BITS - 1;
  localparam int OFS_W    = RB_MIN + 2;
  localparam int ERR_W    = OFS_W + 2;
  localparam int W_A      = (OUT_BITS > OFS_W) ? OUT_BITS : OFS_W;
  localparam int W        = (W_A > VP_BITS + 1) ? W_A : VP_BITS + 1;

  // Configuration.
  logic [VP_BITS-1:0] vp_x_r, vp_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_x_r <= '0;
      vp_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_VIEWPORT_X: vp_x_r <= cfg_wdata;
        REG_VIEWPORT_Y: vp_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Circle state.
  logic                          busy_r, busy_nxt;
  logic signed [COORD_BITS-1:0]  col_r, col_nxt, row_c_r, row_c_nxt;
  logic signed [OFS_W-1:0]       outer_r, outer_nxt, inner_r, inner_nxt;
  logic signed [OFS_W-1:0]       limit_r, limit_nxt, roff_r, roff_nxt;
  logic signed [ERR_W-1:0]       oerr_r, oerr_nxt, ierr_r, ierr_nxt;
  logic [COLOR_BITS-1:0]         color_r, color_nxt;

  // Iteration being emitted and its span index.
  logic                          snap_valid_r, snap_valid_nxt;
  logic [SPAN_IDX_BITS-1:0]      k_r, k_nxt;
  logic signed [COORD_BITS-1:0]  sx_r, sy_r;
  logic signed [OFS_W-1:0]       sr_r, so_r, si_r;
  logic [COLOR_BITS-1:0]         scol_r;
  logic                          slast_r;

  logic is_start, in_fire, emit, out_load, snap_done;

  assign is_start  = (action_t'(in_action) == ACT_START);
  assign out_load  = snap_valid_r & (~out_valid | out_ready);
  assign snap_done = out_load & (k_r == SPAN_LAST);
  assign in_ready  = ~snap_valid_r | snap_done;
  assign in_fire   = in_valid & in_ready;
  assign emit      = in_fire & (is_start | busy_r);

  // Start values and one midpoint step of both circles.
  logic signed [OFS_W-1:0] rad_e, half_e, ld_o, ld_i;
  logic signed [OFS_W-1:0] cur_r, cur_o, cur_i, cur_il, r1, o1, i1;
  logic signed [ERR_W-1:0] cur_oe, cur_ie, oe1, ie1, r1e, o1e, i1e;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic [COLOR_BITS-1:0] cur_col;
  logic diag, busy1;

  always_comb begin
    rad_e  = OFS_W'(in_radius);
    half_e = OFS_W'(in_thickness >> 1);
    ld_o   = rad_e + half_e;
    ld_i   = rad_e - half_e;

    cur_r   = is_start ? '0 : roff_r;
    cur_o   = is_start ? ld_o : outer_r;
    cur_i   = is_start ? ld_i : inner_r;
    cur_il  = is_start ? ld_i : limit_r;
    cur_oe  = is_start ? (ERR_W'(1) - ERR_W'(ld_o)) : oerr_r;
    cur_ie  = is_start ? (ERR_W'(1) - ERR_W'(ld_i)) : ierr_r;
    cur_x   = is_start ? in_center_x : col_r;
    cur_y   = is_start ? in_center_y : row_c_r;
    cur_col = is_start ? in_color : color_r;

    r1  = cur_r + OFS_W'(1);
    r1e = ERR_W'(r1);

    o1  = cur_oe[ERR_W-1] ? cur_o : cur_o - OFS_W'(1);
    o1e = ERR_W'(o1);
    oe1 = cur_oe[ERR_W-1] ? cur_oe + (r1e <<< 1) + ERR_W'(1)
                          : cur_oe + ((r1e - o1e) <<< 1) + ERR_W'(1);

    // Past the inner radius the inner edge rides the diagonal.
    diag = (r1 > cur_il);
    if (diag) begin
      i1  = r1;
      ie1 = cur_ie;
    end else if (cur_ie[ERR_W-1]) begin
      i1  = cur_i;
      ie1 = cur_ie + (r1e <<< 1) + ERR_W'(1);
    end else begin
      i1  = cur_i - OFS_W'(1);
      ie1 = cur_ie + ((r1e - ERR_W'(i1)) <<< 1) + ERR_W'(1);
    end
    i1e = ERR_W'(i1);

    busy1 = (o1 >= r1);
  end

  always_comb begin
    busy_nxt   = busy_r;
    col_nxt    = col_r;
    row_c_nxt  = row_c_r;
    outer_nxt  = outer_r;
    inner_nxt  = inner_r;
    limit_nxt  = limit_r;
    roff_nxt   = roff_r;
    oerr_nxt   = oerr_r;
    ierr_nxt   = ierr_r;
    color_nxt  = color_r;
    if (emit) begin
      busy_nxt  = busy1;
      col_nxt   = cur_x;
      row_c_nxt = cur_y;
      outer_nxt = o1;
      inner_nxt = i1e[OFS_W-1:0];
      limit_nxt = cur_il;
      roff_nxt  = r1;
      oerr_nxt  = oe1;
      ierr_nxt  = ie1;
      color_nxt = cur_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      col_r   <= '0;
      row_c_r <= '0;
      outer_r <= '0;
      inner_r <= '0;
      limit_r <= '0;
      roff_r  <= '0;
      oerr_r  <= '0;
      ierr_r  <= '0;
      color_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      col_r   <= col_nxt;
      row_c_r <= row_c_nxt;
      outer_r <= outer_nxt;
      inner_r <= inner_nxt;
      limit_r <= limit_nxt;
      roff_r  <= roff_nxt;
      oerr_r  <= oerr_nxt;
      ierr_r  <= ierr_nxt;
      color_r <= color_nxt;
    end
  end

  // Snapshot of the octant point emitted by the span stage.
  always_comb begin
    snap_valid_nxt = snap_valid_r;
    k_nxt          = k_r;
    if (out_load) begin
      k_nxt = k_r + SPAN_IDX_BITS'(1);
    end
    if (snap_done) begin
      snap_valid_nxt = 1'b0;
    end
    if (emit) begin
      snap_valid_nxt = 1'b1;
      k_nxt          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
      k_r          <= '0;
    end else begin
      snap_valid_r <= snap_valid_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sx_r    <= cur_x;
      sy_r    <= cur_y;
      sr_r    <= cur_r;
      so_r    <= cur_o;
      si_r    <= cur_i;
      scol_r  <= cur_col;
      slast_r <= ~busy1;
    end
  end

  // Span k of the snapshot, viewport added, wrapped to the output width.
  span_sel_t          sel;
  logic signed [W-1:0] base_f, base_a, vp_f, vp_a, ofs_f, ofs_s, ofs_e;
  logic signed [W-1:0] fixed_w, start_w, end_w;

  always_comb begin
    sel     = span_sel(k_r);
    base_f  = sel.vertical ? W'(sx_r) : W'(sy_r);
    base_a  = sel.vertical ? W'(sy_r) : W'(sx_r);
    vp_f    = sel.vertical ? W'(vp_x_r) : W'(vp_y_r);
    vp_a    = sel.vertical ? W'(vp_y_r) : W'(vp_x_r);
    ofs_f   = sel.fixed_neg ? -W'(sr_r) : W'(sr_r);
    ofs_s   = sel.along_neg ? -W'(so_r) : W'(si_r);
    ofs_e   = sel.along_neg ? -W'(si_r) : W'(so_r);
    fixed_w = base_f + ofs_f + vp_f;
    start_w = base_a + ofs_s + vp_a;
    end_w   = base_a + ofs_e + vp_a;
  end

  logic out_valid_r, out_valid_nxt;

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vertical    <= sel.vertical;
      out_fixed_coord <= fixed_w[OUT_BITS-1:0];
      out_span_start  <= start_w[OUT_BITS-1:0];
      out_span_end    <= end_w[OUT_BITS-1:0];
      out_span_color  <= scol_r;
      out_last_span   <= slast_r & (k_r == SPAN_LAST);
    end
  end

endmodule

// ----- rtl/core/tcsg_checker.sv -----
// Port-level checks of the thick circle span generator core, bound to the core.
// Depends on tcsg_pkg and thick_circle_span_generator_core.
module tcsg_checker #(
  parameter int COORD_BITS = 12
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_action,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               out_vertical,
  input logic signed [COORD_BITS:0]         out_fixed_coord,
  input logic signed [COORD_BITS:0]         out_span_start,
  input logic signed [COORD_BITS:0]         out_span_end,
  input logic [tcsg_pkg::COLOR_BITS-1:0]    out_span_color,
  input logic                               out_last_span
);
  import tcsg_pkg::*;

  // A stalled transaction keeps its span.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertical) &&
      $stable(out_fixed_coord) && $stable(out_span_start) && $stable(out_span_end) &&
      $stable(out_span_color) && $stable(out_last_span))
    else $error("output span changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // With output empty, a start's first span passes the snapshot and output register.
  a_start_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (action_t'(in_action) == ACT_START) && !out_valid
      |-> ##2 out_valid)
    else $error("start transaction produced no span in time");

  // The closing span of a circle is always the eighth, which is vertical.
  a_last_vertical: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_span |-> out_vertical)
    else $error("last span flagged on a horizontal span");

endmodule

bind thick_circle_span_generator_core tcsg_checker #(.COORD_BITS(COORD_BITS)) u_tcsg_checker (.*);
